>>> rtl/ghts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ghts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = CNT_W + 1;

  localparam int GROUP_W = 16;
  localparam int HASH_W  = 64;
  localparam int SLOT_W  = 10;
  localparam int CFG_W   = 11;
  localparam int MATCH_W = 10;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [SLOT_W-1:0]  slot;
    logic [GROUP_W-1:0] group_id;
    logic [HASH_W-1:0]  key_hash;
  } in_req_t;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] match_index;
  } out_req_t;

  typedef struct packed {
    logic start;
    logic wr;
    logic probe;
    logic nbr;
    logic nbr_up;
    logic lo_up;
    logic hi_dn;
    logic first_edge;
    logic last_edge;
    logic hit;
    logic load_out;
  } ghts_cmd_t;

  typedef struct packed {
    logic empty;
    logic grp_lt;
    logic grp_gt;
    logic hash_lt;
    logic hash_gt;
    logic mid_zero;
    logic mid_last;
  } ghts_sts_t;

endpackage

`default_nettype wire

>>> rtl/grouped_hash_table_search.sv
// The block keeps a table of entries, each a group and a hash, which the
// user loads sorted by group and then by hash, and answers lookups on it.
// Requests enter on in_valid / in_stall with in_data. A load request writes
// one entry at its slot, leaves the block idle and gives no result. A lookup
// request runs three binary searches: the first entry of the group, the last
// entry of the group, then the hash within that range. It gives one result
// on out_valid / out_stall with out_data: a found flag and the matching index.
// If the group is absent, only the first search runs. Each probe checks the
// search range and then reads the middle entry; the group searches may also
// read a neighbor entry, each through the single read port of the tables.
// One request is worked on at a time; in_stall is high until it is done.
// The result sits in an output register: a lookup may search while the last
// result waits, then loads once it is taken; a stalled result holds its value.
// cfg_we with cfg_wdata sets the number of entries searched; write it only
// while the block is idle. Reset clears the count and any pending result;
// the table contents are undefined until loaded.

`timescale 1ns / 1ps
`default_nettype none

module grouped_hash_table_search
  import ghts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_req_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_req_t              out_data,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  ghts_cmd_t cmd;
  ghts_sts_t sts;

  ghts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ghts_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/ghts_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ghts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/ghts_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module ghts_dpath
  import ghts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire in_req_t          in_data,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire ghts_cmd_t        cmd,
  output ghts_sts_t             sts,
  output out_req_t              out_data
);

  logic [CFG_W-1:0]         entry_count_r;
  logic [CNT_W-1:0]         n_r, n_nxt, n_clamp;
  logic [GROUP_W-1:0]       key_group_r, key_group_nxt;
  logic [HASH_W-1:0]        key_hash_r, key_hash_nxt;
  logic signed [POS_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0]         mid_r, mid_nxt, mid_comb;
  logic [IDX_W-1:0]         first_r, first_nxt;
  logic                     found_r, found_nxt;
  logic [IDX_W-1:0]         res_idx_r, res_idx_nxt;
  out_req_t                 out_data_r, out_data_nxt;
  logic signed [POS_W:0]    mid_sum;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         wr_addr;
  logic                     wr_en;
  logic [GROUP_W-1:0]       grp_rd;
  logic [HASH_W-1:0]        hash_rd;
  logic [POS_W-1:0]         mid_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  assign n_clamp = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(entry_count_r);

  assign mid_sum  = POS_W'(lo_r) + POS_W'(hi_r) + (POS_W + 1)'(0);
  assign mid_comb = mid_sum[IDX_W:1];
  assign mid_ext  = POS_W'(mid_r);

  assign wr_en   = cmd.wr && (32'(in_data.slot) < 32'(TABLE_DEPTH));
  assign wr_addr = IDX_W'(in_data.slot);

  always_comb begin
    if (cmd.probe) begin
      rd_addr = mid_comb;
    end else if (cmd.nbr_up) begin
      rd_addr = mid_r + IDX_W'(1);
    end else begin
      rd_addr = mid_r - IDX_W'(1);
    end
  end

  ghts_ram #(.WIDTH(GROUP_W), .DEPTH(TABLE_DEPTH)) u_group_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.group_id),
    .rd_addr (rd_addr),
    .rd_data (grp_rd)
  );

  ghts_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_DEPTH)) u_hash_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.key_hash),
    .rd_addr (rd_addr),
    .rd_data (hash_rd)
  );

  always_comb begin
    n_nxt         = n_r;
    key_group_nxt = key_group_r;
    key_hash_nxt  = key_hash_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    first_nxt     = first_r;
    found_nxt     = found_r;
    res_idx_nxt   = res_idx_r;
    out_data_nxt  = out_data_r;

    priority if (cmd.start) begin
      n_nxt         = n_clamp;
      key_group_nxt = in_data.group_id;
      key_hash_nxt  = in_data.key_hash;
      lo_nxt        = '0;
      hi_nxt        = POS_W'(n_clamp) - POS_W'(1);
      found_nxt     = 1'b0;
      res_idx_nxt   = '0;
    end else if (cmd.first_edge) begin
      first_nxt = mid_r;
      lo_nxt    = '0;
      hi_nxt    = POS_W'(n_r) - POS_W'(1);
    end else if (cmd.last_edge) begin
      lo_nxt = POS_W'(first_r);
      hi_nxt = mid_ext;
    end else if (cmd.lo_up) begin
      lo_nxt = mid_ext + POS_W'(1);
    end else if (cmd.hi_dn) begin
      hi_nxt = mid_ext - POS_W'(1);
    end else if (cmd.hit) begin
      found_nxt   = 1'b1;
      res_idx_nxt = mid_r;
    end else begin
    end

    if (cmd.probe) begin
      mid_nxt = mid_comb;
    end
    if (cmd.load_out) begin
      out_data_nxt.found       = found_r;
      out_data_nxt.match_index = MATCH_W'(res_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    key_group_r <= key_group_nxt;
    key_hash_r  <= key_hash_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    first_r     <= first_nxt;
    found_r     <= found_nxt;
    res_idx_r   <= res_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign sts.empty    = lo_r > hi_r;
  assign sts.grp_lt   = grp_rd < key_group_r;
  assign sts.grp_gt   = grp_rd > key_group_r;
  assign sts.hash_lt  = hash_rd < key_hash_r;
  assign sts.hash_gt  = hash_rd > key_hash_r;
  assign sts.mid_zero = (mid_r == '0);
  assign sts.mid_last = (CNT_W'(mid_r) + CNT_W'(1)) >= n_r;

  assign out_data = out_data_r;

endmodule

`default_nettype wire

>>> rtl/ghts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ghts_ctrl
  import ghts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_mode,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire ghts_sts_t sts,
  output ghts_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCHK = 3'd1;
  localparam logic [2:0] S_GRD  = 3'd2;
  localparam logic [2:0] S_GNB  = 3'd3;
  localparam logic [2:0] S_HCHK = 3'd4;
  localparam logic [2:0] S_HRD  = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  localparam logic PH_FIRST = 1'b0;
  localparam logic PH_LAST  = 1'b1;

  logic [2:0] state_r, state_nxt;
  logic       phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       edge_hit;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    edge_hit  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_LOOKUP) begin
            cmd.start = 1'b1;
            phase_nxt = PH_FIRST;
            state_nxt = S_GCHK;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_GCHK: begin
        if (sts.empty) begin
          state_nxt = S_RES;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_GRD;
        end
      end
      S_GRD: begin
        priority if (sts.grp_lt) begin
          cmd.lo_up = 1'b1;
          state_nxt = S_GCHK;
        end else if (sts.grp_gt) begin
          cmd.hi_dn = 1'b1;
          state_nxt = S_GCHK;
        end else if (phase_r == PH_FIRST) begin
          if (sts.mid_zero) begin
            edge_hit = 1'b1;
          end else begin
            cmd.nbr   = 1'b1;
            state_nxt = S_GNB;
          end
        end else begin
          if (sts.mid_last) begin
            edge_hit = 1'b1;
          end else begin
            cmd.nbr    = 1'b1;
            cmd.nbr_up = 1'b1;
            state_nxt  = S_GNB;
          end
        end
      end
      S_GNB: begin
        if (phase_r == PH_FIRST) begin
          if (sts.grp_lt) begin
            edge_hit = 1'b1;
          end else begin
            cmd.hi_dn = 1'b1;
            state_nxt = S_GCHK;
          end
        end else begin
          if (sts.grp_gt) begin
            edge_hit = 1'b1;
          end else begin
            cmd.lo_up = 1'b1;
            state_nxt = S_GCHK;
          end
        end
      end
      S_HCHK: begin
        if (sts.empty) begin
          state_nxt = S_RES;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_HRD;
        end
      end
      S_HRD: begin
        priority if (sts.hash_lt) begin
          cmd.lo_up = 1'b1;
          state_nxt = S_HCHK;
        end else if (sts.hash_gt) begin
          cmd.hi_dn = 1'b1;
          state_nxt = S_HCHK;
        end else begin
          cmd.hit   = 1'b1;
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (edge_hit) begin
      if (phase_r == PH_FIRST) begin
        cmd.first_edge = 1'b1;
        phase_nxt      = PH_LAST;
        state_nxt      = S_GCHK;
      end else begin
        cmd.last_edge = 1'b1;
        state_nxt     = S_HCHK;
      end
    end
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/ghts_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ghts_checker
  import ghts_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire in_req_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire out_req_t out_data
);

  // No result may be pending right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A miss always reports index zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.match_index == '0)
    else $error("miss with nonzero index");

  // A load completes in the cycle it is taken.
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode == MODE_LOAD |=> !in_stall)
    else $error("block busy after load");

  // A lookup leaves the block busy after it is taken.
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode == MODE_LOOKUP |=> in_stall)
    else $error("block not busy after lookup");

endmodule

bind grouped_hash_table_search ghts_checker u_chk (.*);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ghts_pkg::*;

  localparam logic [HASH_W-1:0] HASH_ALL = '1;
  localparam int SETTLE_CYCLES = 120;
  localparam int LONG_HOLD = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  grouped_hash_table_search dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  in_req_t request_q[$];
  out_req_t answer_q[$];

  logic [GROUP_W-1:0] tab_group[TABLE_DEPTH];
  logic [HASH_W-1:0] tab_hash[TABLE_DEPTH];
  logic [CFG_W-1:0] tab_count = '0;

  logic [GROUP_W-1:0] plan_group[TABLE_DEPTH];
  logic [HASH_W-1:0] plan_hash[TABLE_DEPTH];
  int plan_count = 0;

  int send_gap_max = 13;
  int recv_gap_max = 13;
  int gap_left = 0;
  int stall_left = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  logic offer;
  out_req_t want;

  int errors = 0;
  int requests_sent = 0;
  int lookups_sent = 0;
  int answers_checked = 0;
  int sizes_tried = 0;

  function automatic logic group_bound(input int n, input logic [GROUP_W-1:0] g,
                                       input logic want_last, output int pos);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = n - 1;
    pos = 0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (tab_group[mid] < g) begin
        lo = mid + 1;
      end else if (tab_group[mid] > g) begin
        hi = mid - 1;
      end else if (!want_last) begin
        if (mid == 0 || tab_group[mid-1] < g) begin
          pos = mid;
          return 1'b1;
        end
        hi = mid - 1;
      end else begin
        if (mid >= n - 1 || tab_group[mid+1] > g) begin
          pos = mid;
          return 1'b1;
        end
        lo = mid + 1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void apply_request(input in_req_t r);
    int n;
    int lo_pos;
    int hi_pos;
    int mid;
    logic hit;
    out_req_t ans;
    if (r.mode == MODE_LOAD) begin
      tab_group[r.slot] = r.group_id;
      tab_hash[r.slot] = r.key_hash;
      return;
    end
    lookups_sent++;
    ans = '0;
    n = (tab_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(tab_count);
    hit = group_bound(n, r.group_id, 1'b0, lo_pos);
    if (hit) begin
      hit = group_bound(n, r.group_id, 1'b1, hi_pos);
    end
    if (hit) begin
      while (lo_pos <= hi_pos) begin
        mid = (lo_pos + hi_pos) / 2;
        if (tab_hash[mid] < r.key_hash) begin
          lo_pos = mid + 1;
        end else if (tab_hash[mid] > r.key_hash) begin
          hi_pos = mid - 1;
        end else begin
          ans.found = 1'b1;
          ans.match_index = mid[MATCH_W-1:0];
          break;
        end
      end
    end
    answer_q.push_back(ans);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left = 0;
    end else begin
      if (cfg_we) begin
        tab_count = cfg_wdata;
      end
      offer = in_valid;
      if (in_valid && !in_stall) begin
        apply_request(in_data);
        requests_sent++;
        offer = 1'b0;
        gap_left = $urandom_range(0, send_gap_max);
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          in_data <= request_q.pop_front();
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        answers_checked++;
        if (answer_q.size() == 0) begin
          $error("result with no lookup waiting: found=%0d match_index=%0d",
                 out_data.found, out_data.match_index);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            errors++;
          end
          if (out_data.match_index !== want.match_index) begin
            $error("match_index: expected %0d, got %0d", want.match_index,
                   out_data.match_index);
            errors++;
          end
        end
        stall_left = $urandom_range(0, recv_gap_max);
      end
      if (hold_seen != hold_toggle) begin
        hold_seen = hold_toggle;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_load(input int slot, input logic [GROUP_W-1:0] g,
                           input logic [HASH_W-1:0] h);
    in_req_t r;
    r.mode = MODE_LOAD;
    r.slot = slot[SLOT_W-1:0];
    r.group_id = g;
    r.key_hash = h;
    plan_group[slot] = g;
    plan_hash[slot] = h;
    request_q.push_back(r);
  endtask

  task automatic push_lookup(input logic [GROUP_W-1:0] g, input logic [HASH_W-1:0] h);
    in_req_t r;
    r.mode = MODE_LOOKUP;
    r.slot = SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
    r.group_id = g;
    r.key_hash = h;
    request_q.push_back(r);
  endtask

  task automatic settle();
    while (request_q.size() != 0 || in_valid || answer_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_count(input int value);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    plan_count = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
    sizes_tried++;
  endtask

  task automatic fill_sorted_table();
    int g;
    logic [HASH_W-1:0] h;
    g = $urandom_range(0, 30000);
    h = {$urandom, $urandom} >> 1;
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      if (s > 0) begin
        if ($urandom_range(0, 3) == 0) begin
          if (g + 150 < 65536) begin
            g = g + $urandom_range(1, 150);
          end
          h = {$urandom, $urandom} >> 1;
        end else if ($urandom_range(0, 4) != 0) begin
          h = h + (64'($urandom) << $urandom_range(0, 8));
        end
      end
      push_load(s, g[GROUP_W-1:0], h);
    end
  endtask

  task automatic random_request();
    int kind;
    int i;
    kind = $urandom_range(0, 39);
    if (kind == 0) begin
      push_load($urandom_range(0, TABLE_DEPTH - 1), GROUP_W'($urandom_range(0, 65535)),
                {$urandom, $urandom});
    end else if (plan_count == 0 || kind >= 34) begin
      push_lookup(GROUP_W'($urandom_range(0, 65535)), {$urandom, $urandom});
    end else begin
      i = $urandom_range(0, plan_count - 1);
      if (kind < 26) begin
        push_lookup(plan_group[i], plan_hash[i]);
      end else if (kind < 28) begin
        push_lookup(plan_group[i], plan_hash[i] + 1);
      end else if (kind < 30) begin
        push_lookup(plan_group[i], plan_hash[i] - 1);
      end else begin
        push_lookup(plan_group[i], {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    int sizes[7];
    int per_phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_count(0);
    push_lookup(16'h0000, '0);
    push_lookup(16'hFFFF, HASH_ALL);
    push_load(0, 16'h0000, 64'd0);
    push_load(1, 16'h0000, 64'd5);
    push_load(2, 16'h0000, HASH_ALL);
    push_load(3, 16'h0007, 64'd1);
    push_load(4, 16'h0007, 64'd2);
    push_load(5, 16'h0007, 64'd3);
    push_load(6, 16'hFFFF, 64'd0);
    push_load(7, 16'hFFFF, HASH_ALL);
    push_load(TABLE_DEPTH - 1, 16'hFFFF, HASH_ALL);
    set_count(8);
    push_lookup(16'h0000, 64'd0);
    push_lookup(16'h0000, 64'd5);
    push_lookup(16'h0000, HASH_ALL);
    push_lookup(16'h0007, 64'd2);
    push_lookup(16'h0007, 64'd4);
    push_lookup(16'h0003, 64'd0);
    push_lookup(16'hFFFF, 64'd0);
    push_lookup(16'hFFFF, HASH_ALL);
    push_lookup(16'h8000, 64'd0);
    set_count(1);
    push_lookup(16'h0000, 64'd0);
    push_lookup(16'h0000, 64'd5);
    push_load(4, 16'h0003, 64'd9);
    set_count(8);
    push_lookup(16'h0007, 64'd1);
    push_lookup(16'h0007, 64'd3);
    push_lookup(16'h0003, 64'd9);

    fill_sorted_table();
    sizes = '{TABLE_DEPTH, 2047, TABLE_DEPTH + 1, $urandom_range(2, TABLE_DEPTH - 1),
              $urandom_range(2, 16), 1, 0};
    for (int p = 0; p < 7; p++) begin
      set_count(sizes[p]);
      per_phase = (p < 5) ? 130 : 40;
      case (p)
        1: begin
          send_gap_max = 0;
          hold_toggle = ~hold_toggle;
          for (int k = 0; k < 40; k++) random_request();
          settle();
          send_gap_max = 13;
        end
        2: begin
          send_gap_max = 0;
          recv_gap_max = 0;
        end
        3: begin
          send_gap_max = 13;
          recv_gap_max = 0;
        end
        4: begin
          send_gap_max = 0;
          recv_gap_max = 13;
        end
        default: begin
          send_gap_max = 13;
          recv_gap_max = 13;
        end
      endcase
      for (int k = 0; k < per_phase; k++) begin
        random_request();
        if (p == 3 && k == per_phase / 2) begin
          settle();
        end
      end
    end

    settle();
    if (answer_q.size() != 0) begin
      $error("%0d lookup results never arrived", answer_q.size());
      errors++;
    end
    $display("Sent %0d requests, %0d of them lookups, over %0d table size settings.",
             requests_sent, lookups_sent, sizes_tried);
    $display("Checked %0d results with random stalls, one long output hold and idle pauses.",
             answers_checked);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/ghts_pkg.sv
rtl/ghts_ram.sv
rtl/ghts_dpath.sv
rtl/ghts_ctrl.sv
rtl/grouped_hash_table_search.sv
rtl/ghts_checker.sv
verif/testbench.sv
